// ----- rtl/tbc_pkg.sv -----
package tbc_pkg;

  // Pipeline flow control handed to each datapath section.
  typedef struct packed {
    logic adv;  // every stage register loads this cycle
    logic vld;  // the item entering the section is valid
  } tbc_flow_t;

endpackage

// ----- rtl/tbc_cross.sv -----
module tbc_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbc_pkg::tbc_flow_t           flow_i,
  input  logic signed [COORD_BITS-1:0] pt_i [3],
  input  logic signed [COORD_BITS-1:0] va_i [3],
  input  logic signed [COORD_BITS-1:0] vb_i [3],
  input  logic signed [COORD_BITS-1:0] vc_i [3],
  output logic                         vld_o,
  // Normals indexed [normal][component]: N, Npbc, Npca.
  output logic signed [2*COORD_BITS+2:0] nrm_o [3][3]
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [DW-1:0] ba_q [3];
  logic signed [DW-1:0] ca_q [3];
  logic signed [DW-1:0] ap_q [3];
  logic signed [DW-1:0] bp_q [3];
  logic signed [DW-1:0] cp_q [3];
  logic signed [DW-1:0] lhs [3][3];
  logic signed [DW-1:0] rhs [3][3];
  logic signed [PW-1:0] pa_q [3][3];
  logic signed [PW-1:0] pb_q [3][3];
  logic signed [NW-1:0] nrm_q [3][3];
  logic                 s1_vld_q, s2_vld_q, s3_vld_q;

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (flow_i.adv) begin
      s1_vld_q <= flow_i.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Edge vectors of the triangle and from the point to each vertex.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv) begin
      for (int k = 0; k < 3; k++) begin
        ba_q[k] <= DW'(vb_i[k]) - DW'(va_i[k]);
        ca_q[k] <= DW'(vc_i[k]) - DW'(va_i[k]);
        ap_q[k] <= DW'(va_i[k]) - DW'(pt_i[k]);
        bp_q[k] <= DW'(vb_i[k]) - DW'(pt_i[k]);
        cp_q[k] <= DW'(vc_i[k]) - DW'(pt_i[k]);
      end
    end
  end

  // Operand pairs of the three cross products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lhs[0][k] = ba_q[k];
      rhs[0][k] = ca_q[k];
      lhs[1][k] = bp_q[k];
      rhs[1][k] = cp_q[k];
      lhs[2][k] = cp_q[k];
      rhs[2][k] = ap_q[k];
    end
  end

  // Both products of every cross-product component.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          pa_q[c][k] <= PW'(lhs[c][(k == 2) ? 0 : k + 1]) * PW'(rhs[c][(k == 0) ? 2 : k - 1]);
          pb_q[c][k] <= PW'(lhs[c][(k == 0) ? 2 : k - 1]) * PW'(rhs[c][(k == 2) ? 0 : k + 1]);
        end
      end
    end
  end

  // Component differences.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          nrm_q[c][k] <= NW'(pa_q[c][k]) - NW'(pb_q[c][k]);
        end
      end
    end
  end

  assign nrm_o = nrm_q;
  assign vld_o = s3_vld_q;

endmodule

// ----- rtl/tbc_dot.sv -----
module tbc_dot #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tbc_pkg::tbc_flow_t             flow_i,
  input  logic signed [2*COORD_BITS+2:0] nrm_i [3][3],
  output logic                           vld_o,
  // Dot products: N.N (four times the squared area), N.Npbc, N.Npca.
  output logic signed [4*COORD_BITS+7:0] dot_o [3]
);

  localparam int NW = 2 * COORD_BITS + 3;
  localparam int LW = NW / 2;
  localparam int TW = 2 * NW;
  localparam int AW = TW + 2;

  logic signed [TW-1:0] ph_q [3][3];
  logic signed [TW-1:0] pl_q [3][3];
  logic signed [TW-1:0] term_q [3][3];
  logic signed [AW-1:0] dot_q [3];
  logic                 s1_vld_q, s2_vld_q, s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (flow_i.adv) begin
      s1_vld_q <= flow_i.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Partial products: N component times the upper and lower half of the other operand.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv) begin
      for (int d = 0; d < 3; d++) begin
        for (int k = 0; k < 3; k++) begin
          ph_q[d][k] <= TW'(nrm_i[0][k]) * TW'($signed(nrm_i[d][k][NW-1:LW]));
          pl_q[d][k] <= TW'(nrm_i[0][k]) * TW'($signed({1'b0, nrm_i[d][k][LW-1:0]}));
        end
      end
    end
  end

  // Recombine the halves into full component products.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv) begin
      for (int d = 0; d < 3; d++) begin
        for (int k = 0; k < 3; k++) begin
          term_q[d][k] <= (ph_q[d][k] <<< LW) + pl_q[d][k];
        end
      end
    end
  end

  // Sum over the three components.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv) begin
      for (int d = 0; d < 3; d++) begin
        dot_q[d] <= AW'(term_q[d][0]) + AW'(term_q[d][1]) + AW'(term_q[d][2]);
      end
    end
  end

  assign dot_o = dot_q;
  assign vld_o = s3_vld_q;

endmodule

// ----- rtl/tbc_div.sv -----
module tbc_div #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  logic signed [4*COORD_BITS+9:0] num_i,
  input  logic        [4*COORD_BITS+7:0] area_i,
  output logic signed [FRAC_BITS+2:0]    weight_o
);

  localparam int WW = 4 * COORD_BITS + 10;
  localparam int AW = 4 * COORD_BITS + 8;
  localparam int QB = FRAC_BITS + 3;
  localparam int XW = WW + FRAC_BITS + 2;
  localparam logic [QB-1:0] TWO = QB'(2) << FRAC_BITS;

  logic          neg_a_q;
  logic [WW-1:0] mag_a_q;
  logic [AW-1:0] area_a_q;

  logic [XW-1:0] r_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [AW:0]   d_q   [QB+1];
  logic          neg_q [QB+1];
  logic          sat_q [QB+1];

  logic [XW-1:0] trial [QB];
  logic [XW-1:0] r_nx  [QB];
  logic [QB-1:0] q_nx  [QB];
  logic [QB-1:0] q_clamp;
  logic signed [QB-1:0] weight_q;

  // Sign and magnitude of the numerator.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg_a_q  <= num_i[WW-1];
      mag_a_q  <= num_i[WW-1] ? WW'(-num_i) : WW'(num_i);
      area_a_q <= area_i;
    end
  end

  // Saturation check and the rounded dividend (2*mag << frac) + area over 2*area.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sat_q[0] <= (WW + 1)'(mag_a_q) > (WW + 1)'({area_a_q, 1'b0});
      r_q[0]   <= (XW'(mag_a_q) << (FRAC_BITS + 1)) + XW'(area_a_q);
      q_q[0]   <= '0;
      d_q[0]   <= {area_a_q, 1'b0};
      neg_q[0] <= neg_a_q;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      trial[s] = XW'(d_q[s]) << (QB - 1 - s);
      if (r_q[s] >= trial[s]) begin
        r_nx[s] = r_q[s] - trial[s];
        q_nx[s] = {q_q[s][QB-2:0], 1'b1};
      end else begin
        r_nx[s] = r_q[s];
        q_nx[s] = {q_q[s][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < QB; s++) begin
        r_q[s+1]   <= r_nx[s];
        q_q[s+1]   <= q_nx[s];
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  // Clamp to two and restore the sign.
  assign q_clamp = (sat_q[QB] || (q_q[QB] > TWO)) ? TWO : q_q[QB];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      weight_q <= neg_q[QB] ? $signed(-q_clamp) : $signed(q_clamp);
    end
  end

  assign weight_o = weight_q;

endmodule

// ----- rtl/triangle_barycentric_coords.sv -----
// Barycentric weights of a point against a triangle, fully pipelined.
// The restoring divider, one quotient bit per stage, sets most of the pipeline depth.
// Throughput: one transaction per cycle; all stages stall together on output back-pressure.
// Reset (rst_ni low, asynchronous): valid bits cleared, tolerance register set to zero.
module triangle_barycentric_coords #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Tolerance register write.
  input  logic                 cfg_we_i,
  input  logic [FRAC_BITS:0]   cfg_wdata_i,
  // tdata: point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z, zero pad.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tdata: weight_u, weight_v, weight_w, inside_res, degenerate, zero pad.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((3*FRAC_BITS+9+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CB   = COORD_BITS;
  localparam int NW   = 2 * CB + 3;
  localparam int AW   = 4 * CB + 8;
  localparam int WW   = AW + 2;
  localparam int TB   = FRAC_BITS + 1;
  localparam int WB   = FRAC_BITS + 3;
  localparam int CHW  = 32;
  localparam int NCH  = (AW + CHW - 1) / CHW;
  localparam int PWD  = NCH * CHW + TB;
  localparam int CMW  = WW + FRAC_BITS + 2;
  localparam int DLAT = FRAC_BITS + 6;
  localparam int LL   = DLAT - 3;

  logic              adv;
  logic [TB-1:0]     tol_q;

  logic signed [CB-1:0] pt [3];
  logic signed [CB-1:0] va [3];
  logic signed [CB-1:0] vb [3];
  logic signed [CB-1:0] vc [3];

  logic              cross_vld, dot_vld;
  logic signed [NW-1:0] nrm [3][3];
  logic signed [AW-1:0] dots [3];

  logic              v_t1_q, v_t2_q, v_t3_q, v_t4_q;
  logic              dg_t1_q, dg_t2_q, dg_t3_q, dg_t4_q;
  logic [AW-1:0]     area_t1_q, area_t2_q;
  logic signed [WW-1:0] num_t1_q [3];
  logic signed [WW-1:0] num_t2_q [3];
  logic [CHW+TB-1:0] ch_q [NCH];
  logic [NCH*CHW-1:0] area_pad;
  logic [PWD-1:0]    p_sum;
  logic [PWD-1:0]    p_q;
  logic signed [CMW-1:0] lo_q, hi_q;
  logic signed [CMW-1:0] sc_q [3];
  logic              ins_q;
  logic [LL-1:0]     vline_q, dline_q, iline_q;

  logic signed [WB-1:0] w_u, w_v, w_w;
  logic              degen;

  // One shared advance for the whole pipeline: move unless the output is held.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Unpack the input transaction.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt[k] = $signed(s_axis_tdata[k*CB +: CB]);
      va[k] = $signed(s_axis_tdata[(3+k)*CB +: CB]);
      vb[k] = $signed(s_axis_tdata[(6+k)*CB +: CB]);
      vc[k] = $signed(s_axis_tdata[(9+k)*CB +: CB]);
    end
  end

  tbc_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flow_i ('{adv: adv, vld: s_axis_tvalid}),
    .pt_i   (pt),
    .va_i   (va),
    .vb_i   (vb),
    .vc_i   (vc),
    .vld_o  (cross_vld),
    .nrm_o  (nrm)
  );

  tbc_dot #(.COORD_BITS(COORD_BITS)) u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flow_i ('{adv: adv, vld: cross_vld}),
    .nrm_i  (nrm),
    .vld_o  (dot_vld),
    .dot_o  (dots)
  );

  // Valid pipeline, then a delay line matching the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_t1_q  <= 1'b0;
      v_t2_q  <= 1'b0;
      v_t3_q  <= 1'b0;
      v_t4_q  <= 1'b0;
      vline_q <= '0;
    end else if (adv) begin
      v_t1_q  <= dot_vld;
      v_t2_q  <= v_t1_q;
      v_t3_q  <= v_t2_q;
      v_t4_q  <= v_t3_q;
      vline_q <= {vline_q[LL-2:0], v_t4_q};
    end
  end

  assign area_pad = (NCH * CHW)'($unsigned(dots[0]));

  // Third numerator, zero-area flag and the area times tolerance partials.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_t1_q   <= $unsigned(dots[0]);
      dg_t1_q     <= (dots[0] == '0);
      num_t1_q[0] <= WW'(dots[1]);
      num_t1_q[1] <= WW'(dots[2]);
      num_t1_q[2] <= WW'(dots[0]) - WW'(dots[1]) - WW'(dots[2]);
      for (int j = 0; j < NCH; j++) begin
        ch_q[j] <= (CHW + TB)'(area_pad[j*CHW +: CHW]) * (CHW + TB)'(tol_q);
      end
    end
  end

  // Collect the tolerance partials.
  always_comb begin
    p_sum = '0;
    for (int j = 0; j < NCH; j++) begin
      p_sum = p_sum + (PWD'(ch_q[j]) << (j * CHW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q       <= p_sum;
      area_t2_q <= area_t1_q;
      num_t2_q  <= num_t1_q;
      dg_t2_q   <= dg_t1_q;
    end
  end

  // Inclusion bounds scaled by the area, compared against the scaled numerators.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q    <= CMW'(0) - $signed(CMW'(p_q));
      hi_q    <= $signed((CMW'(area_t2_q) << FRAC_BITS) + CMW'(p_q));
      dg_t3_q <= dg_t2_q;
      for (int k = 0; k < 3; k++) begin
        sc_q[k] <= CMW'(num_t2_q[k]) <<< FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ins_q   <= (sc_q[0] >= lo_q) && (sc_q[0] <= hi_q)
              && (sc_q[1] >= lo_q) && (sc_q[1] <= hi_q)
              && (sc_q[2] >= lo_q) && (sc_q[2] <= hi_q);
      dg_t4_q <= dg_t3_q;
      dline_q <= {dline_q[LL-2:0], dg_t4_q};
      iline_q <= {iline_q[LL-2:0], ins_q};
    end
  end

  // One divider per weight.
  tbc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .num_i    (num_t1_q[0]),
    .area_i   (area_t1_q),
    .weight_o (w_u)
  );

  tbc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .num_i    (num_t1_q[1]),
    .area_i   (area_t1_q),
    .weight_o (w_v)
  );

  tbc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_w (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .num_i    (num_t1_q[2]),
    .area_i   (area_t1_q),
    .weight_o (w_w)
  );

  // Pack the result; a zero-area triangle reports zero weights and outside.
  assign degen         = dline_q[LL-1];
  assign m_axis_tvalid = vline_q[LL-1];

  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[WB-1:0]    = degen ? '0 : w_u;
    m_axis_tdata[2*WB-1:WB] = degen ? '0 : w_v;
    m_axis_tdata[3*WB-1:2*WB] = degen ? '0 : w_w;
    m_axis_tdata[3*WB]      = iline_q[LL-1] && !degen;
    m_axis_tdata[3*WB+1]    = degen;
  end

endmodule

// ----- rtl/tbc_checker.sv -----
module tbc_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((3*FRAC_BITS+9+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int WB = FRAC_BITS + 3;
  localparam logic signed [WB-1:0] TWO = WB'(2) << FRAC_BITS;

  logic signed [WB-1:0] w_u, w_v, w_w;
  logic                 w_ok;

  assign w_u  = $signed(m_axis_tdata[WB-1:0]);
  assign w_v  = $signed(m_axis_tdata[2*WB-1:WB]);
  assign w_w  = $signed(m_axis_tdata[3*WB-1:2*WB]);
  assign w_ok = (w_u <= TWO) && (w_u >= -TWO) && (w_v <= TWO) && (w_v >= -TWO)
             && (w_w <= TWO) && (w_w >= -TWO);

  // A stalled result transaction keeps its valid and payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A zero-area triangle reports zero weights and outside.
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3*WB+1] |-> m_axis_tdata[3*WB:0] == '0)
    else $error("degenerate result carries weights");

  // Weights are saturated to plus or minus two.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> w_ok)
    else $error("weight outside saturation range");

  // An empty output register never blocks the input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind triangle_barycentric_coords tbc_checker #(.FRAC_BITS(FRAC_BITS)) u_tbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
